### rtl/core/q14e_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q14e_pkg
// Shared types, constants and helper functions for the Q14 exponential
// series block.
// ----------------------------------------------------------------------------
package q14e_pkg;

    // word and index widths
    localparam int WORD_W     = 32;
    localparam int COEF_COUNT = 7;
    localparam int IDX_W      = 3;

    // default number of series terms
    localparam int SERIES_TERMS_DEF = 7;

    // fixed-point constants
    localparam logic [WORD_W-1:0] ONE_Q14    = 32'h0000_4000;
    localparam logic [WORD_W-1:0] SMALL_BIAS = 32'h0000_3fff;
    localparam logic [WORD_W-1:0] SMALL_SPAN = 32'h0000_7ffe;
    localparam logic [WORD_W-1:0] WORD_MIN   = 32'h8000_0000;
    localparam logic [WORD_W-1:0] WORD_ZERO  = 32'h0000_0000;

    // request to the shared multiplier
    typedef struct packed {
        logic              en;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
    } t_mul_req;

    // series coefficients, Q14 reciprocal factorials
    function automatic logic [WORD_W-1:0] coef(input logic [IDX_W-1:0] idx);
        logic [WORD_W-1:0] c;
        case (idx)
            3'd0:    c = 32'd16384;
            3'd1:    c = 32'd8192;
            3'd2:    c = 32'd2730;
            3'd3:    c = 32'd683;
            3'd4:    c = 32'd136;
            3'd5:    c = 32'd23;
            3'd6:    c = 32'd3;
            default: c = 32'd0;
        endcase
        return c;
    endfunction

    // arithmetic shift right by 14
    function automatic logic [WORD_W-1:0] asr14(input logic [WORD_W-1:0] v);
        return {{14{v[WORD_W-1]}}, v[WORD_W-1:14]};
    endfunction

endpackage

### rtl/core/q14e_arg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q14e_arg_if
// Argument channel: valid/ready handshake carrying one Q14 exponent.
// ----------------------------------------------------------------------------
interface q14e_arg_if;
    logic        valid;
    logic        ready;
    logic [31:0] exponent_q14;

    modport source (output valid, output exponent_q14, input ready);
    modport sink   (input valid, input exponent_q14, output ready);
endinterface

### rtl/core/q14e_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q14e_res_if
// Result channel: valid/ready handshake carrying one Q14 exponential.
// ----------------------------------------------------------------------------
interface q14e_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] exp_q14;

    modport source (output valid, output exp_q14, input ready);
    modport sink   (input valid, input exp_q14, output ready);
endinterface

### rtl/core/q14e_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q14e_mul
// Shared 32x32 multiplier keeping the low 32 bits of the product in a
// register. Used for both the coefficient and the term products.
// ----------------------------------------------------------------------------
module q14e_mul
    import q14e_pkg::*;
(
    input  logic              i_clk,
    input  t_mul_req          i_req,
    output logic [WORD_W-1:0] o_prod
);

    logic [2*WORD_W-1:0] full_prod;
    logic [WORD_W-1:0]   r_prod;

    // full product, only the wrapped low word is kept
    assign full_prod = {{WORD_W{1'b0}}, i_req.a} * {{WORD_W{1'b0}}, i_req.b};

    // product register
    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_prod <= full_prod[WORD_W-1:0];
        end
    end

    assign o_prod = r_prod;

endmodule

### rtl/core/q14e_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q14e_seq
// Term sequencer: walks the series one term at a time, issuing a
// coefficient product and a next-term product to the shared multiplier,
// accumulating the sum and holding the result in an output register.
// ----------------------------------------------------------------------------
module q14e_seq
    import q14e_pkg::*;
#(
    parameter int SERIES_TERMS = SERIES_TERMS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_arg_valid,
    output logic              o_arg_ready,
    input  logic [WORD_W-1:0] i_arg_x,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output logic [WORD_W-1:0] o_res_data,
    output t_mul_req          o_mul_req,
    input  logic [WORD_W-1:0] i_mul_prod
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_COEF,
        S_TERM,
        S_UPD,
        S_DONE
    } t_state;

    t_state            r_state;
    logic [WORD_W-1:0] r_x;
    logic [WORD_W-1:0] r_term;
    logic [WORD_W-1:0] r_sum;
    logic [IDX_W-1:0]  r_idx;
    logic              r_large;
    logic              r_res_valid;
    logic [WORD_W-1:0] r_res_data;

    logic [WORD_W-1:0] op_a;
    logic [WORD_W-1:0] contrib;
    logic [WORD_W-1:0] biased;
    logic              stop;
    logic              last;
    logic              arg_xfer;
    logic              res_free;

    // operand and contribution selection for the two paths
    assign op_a    = r_large ? asr14(r_term) : r_term;
    assign contrib = r_large ? i_mul_prod : asr14(i_mul_prod);
    assign stop    = (contrib == WORD_ZERO) || (contrib == WORD_MIN);
    assign last    = (r_idx == IDX_W'(SERIES_TERMS - 1));

    // path select: |x| above the small range
    assign biased  = i_arg_x + SMALL_BIAS;

    // handshake
    assign o_arg_ready = (r_state == S_IDLE);
    assign arg_xfer    = i_arg_valid && o_arg_ready;
    assign res_free    = !r_res_valid || i_res_ready;

    // multiplier request: coefficient product, then next-term product
    always_comb begin
        o_mul_req.en = (r_state == S_COEF) || (r_state == S_TERM);
        o_mul_req.a  = op_a;
        o_mul_req.b  = (r_state == S_COEF) ? coef(r_idx) : r_x;
    end

    // sequencer state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res_valid <= 1'b0;
            r_idx       <= '0;
            r_large     <= 1'b0;
        end else begin
            // result register drained, unless refilled below
            if (r_res_valid && i_res_ready && (r_state != S_DONE)) begin
                r_res_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (arg_xfer) begin
                        r_x     <= i_arg_x;
                        r_term  <= i_arg_x;
                        r_sum   <= ONE_Q14;
                        r_idx   <= '0;
                        r_large <= (biased > SMALL_SPAN);
                        r_state <= S_COEF;
                    end
                end
                S_COEF: begin
                    r_state <= S_TERM;
                end
                S_TERM: begin
                    r_sum <= r_sum + contrib;
                    if (stop || last) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_term  <= r_large ? i_mul_prod : asr14(i_mul_prod);
                    r_idx   <= r_idx + 1'b1;
                    r_state <= S_COEF;
                end
                S_DONE: begin
                    if (res_free) begin
                        r_res_valid <= 1'b1;
                        r_res_data  <= r_sum;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res_data  = r_res_data;

endmodule

### rtl/core/q14_exp_series_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q14_exp_series_top
// Q14 exponential by a Maclaurin series of up to seven terms, evaluated on
// one shared multiplier under a small term sequencer.
// ----------------------------------------------------------------------------
//  channel   direction  payload                 handshake
//  i_arg     in         exponent_q14 [31:0] s   valid / ready
//  o_res     out        exp_q14      [31:0] s   valid / ready
//
//  An item walks S_COEF, S_TERM and S_UPD once per term summed (1 to
//  SERIES_TERMS, fewer on an early stop), the last term going from S_TERM
//  to S_DONE instead; each term costs two passes through the multiplier. A
//  new argument is taken only in S_IDLE, once the previous one has reached the
//  result register. A finished result waits in the output register, so the next
//  argument may transfer while the previous result is still stalled. Reset is
//  synchronous, active low, and clears the sequencer and the result valid.
// ----------------------------------------------------------------------------
module q14_exp_series_top
    import q14e_pkg::*;
#(
    parameter int SERIES_TERMS = SERIES_TERMS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    q14e_arg_if.sink   i_arg,
    q14e_res_if.source o_res
);

    t_mul_req          mul_req;
    logic [WORD_W-1:0] mul_prod;

    // shared multiplier
    q14e_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (mul_req),
        .o_prod (mul_prod)
    );

    // term sequencer and accumulator
    q14e_seq #(
        .SERIES_TERMS (SERIES_TERMS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_arg_valid (i_arg.valid),
        .o_arg_ready (i_arg.ready),
        .i_arg_x     (i_arg.exponent_q14),
        .o_res_valid (o_res.valid),
        .i_res_ready (o_res.ready),
        .o_res_data  (o_res.exp_q14),
        .o_mul_req   (mul_req),
        .i_mul_prod  (mul_prod)
    );

endmodule
